// ===== design/software_timer_pool_assert.svh =====
// Assertion macros for the timer pool checker.
`ifndef SOFTWARE_TIMER_POOL_ASSERT_SVH
`define SOFTWARE_TIMER_POOL_ASSERT_SVH

// ante implies cons on the same edge
`define SWTP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("software_timer_pool: property violated");

// ante implies cons on the next edge
`define SWTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("software_timer_pool: property violated");

// ante implies cons a fixed number of edges later
`define SWTP_ASSERT_LATER(label, clk, rst_n, dly, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
		else $error("software_timer_pool: property violated");

`endif

// ===== design/swtp_pkg.sv =====
`timescale 1ns / 1ps

package swtp_pkg;

	localparam int NUM_TIMERS_DEF = 16;
	localparam int MAX_RESULTS    = 16;
	localparam int FCW            = $clog2(MAX_RESULTS + 1);

	localparam logic [2:0] REQ_ADD    = 3'd0;
	localparam logic [2:0] REQ_DEL    = 3'd1;
	localparam logic [2:0] REQ_RELOAD = 3'd2;
	localparam logic [2:0] REQ_STOP   = 3'd3;
	localparam logic [2:0] REQ_TICK   = 3'd4;
	localparam logic [2:0] REQ_FIND   = 3'd5;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_FULL        = 3'd1;
	localparam logic [2:0] ST_BAD_INDEX   = 3'd2;
	localparam logic [2:0] ST_FREE        = 3'd3;
	localparam logic [2:0] ST_RUNNING     = 3'd4;
	localparam logic [2:0] ST_NOT_RUNNING = 3'd5;
	localparam logic [2:0] ST_NOT_FOUND   = 3'd6;

	typedef struct packed {
		logic load;
		logic simple;
		logic scan;
		logic flush;
	} swtp_cmd_t;

	typedef struct packed {
		logic scan_done;
	} swtp_stat_t;

endpackage

// ===== design/swtp_ctrl.sv =====
`timescale 1ns / 1ps

module swtp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [2:0]          req_type,
	input  swtp_pkg::swtp_stat_t stat,
	output swtp_pkg::swtp_cmd_t  cmd,
	output logic                busy
);
	import swtp_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SIMPLE = 2'd1;
	localparam logic [1:0] S_SCAN   = 2'd2;
	localparam logic [1:0] S_FLUSH  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (req_type inside {REQ_DEL, REQ_RELOAD, REQ_STOP}) begin
						state_nxt = S_SIMPLE;
					end else if (req_type inside {REQ_ADD, REQ_TICK, REQ_FIND}) begin
						state_nxt = S_SCAN;
					end
				end
			end
			S_SIMPLE: begin
				cmd.simple = 1'b1;
				state_nxt  = S_IDLE;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) begin
					state_nxt = S_FLUSH;
				end
			end
			S_FLUSH: begin
				cmd.flush = 1'b1;
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== design/swtp_datapath.sv =====
`timescale 1ns / 1ps

module swtp_datapath #(
	parameter int NUM_TIMERS = swtp_pkg::NUM_TIMERS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  swtp_pkg::swtp_cmd_t  cmd,
	output swtp_pkg::swtp_stat_t stat,
	input  logic [2:0]           req_type,
	input  logic [7:0]           slot_index,
	input  logic                 periodic,
	input  logic [31:0]          timeout_ticks,
	input  logic [7:0]           user_id,
	input  logic [31:0]          now_tick,
	output logic                 strobe,
	output logic [2:0]           status,
	output logic [3:0]           result_slot,
	output logic [7:0]           fired_id,
	output logic                 fired,
	output logic                 last
);
	import swtp_pkg::*;

	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CW = $clog2(NUM_TIMERS + 1);

	// latched request word
	logic [2:0]  type_q;
	logic [7:0]  idx_q;
	logic        per_q;
	logic [31:0] tmo_q;
	logic [7:0]  uid_q;
	logic [31:0] now_q;

	// per-slot flags
	logic [NUM_TIMERS-1:0] used_q;
	logic [NUM_TIMERS-1:0] run_q;
	logic [NUM_TIMERS-1:0] perf_q;
	logic [CW-1:0]         free_q;

	// slot memories
	logic [31:0] tmo_mem   [NUM_TIMERS];
	logic [31:0] start_mem [NUM_TIMERS];
	logic [7:0]  uid_mem   [NUM_TIMERS];

	// scan pipeline
	logic [IW:0]   cnt_q;
	logic          issue;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;
	logic [31:0]   rd_tmo_s1;
	logic [31:0]   rd_start_s1;
	logic [7:0]    rd_uid_s1;

	logic          found_q;
	logic [IW-1:0] found_idx_q;
	logic          pend_q;
	logic [IW-1:0] pend_idx_q;
	logic [7:0]    pend_id_q;
	logic [FCW-1:0] fcnt_q;

	logic [2:0]  status_q;
	logic [3:0]  slot_q;
	logic [7:0]  id_q;
	logic        fired_q;
	logic        last_q;
	logic        strobe_q;

	logic [IW-1:0] tidx;
	logic          bad;
	logic [2:0]    s_status;
	logic          do_del;
	logic          do_reload;
	logic          do_stop;

	logic [31:0] elapsed;
	logic        do_fire;
	logic        do_take;
	logic        do_match;
	logic        fire_per;

	logic          start_we;
	logic [IW-1:0] start_wa;

	logic [IW+3:0] found_ext;
	logic [IW+3:0] pend_ext;

	assign tidx = idx_q[IW-1:0];
	assign bad  = (idx_q >= 8'(NUM_TIMERS));

	always_comb begin
		s_status  = ST_OK;
		do_del    = 1'b0;
		do_reload = 1'b0;
		do_stop   = 1'b0;
		case (type_q)
			REQ_DEL: begin
				if (bad) begin
					s_status = ST_BAD_INDEX;
				end else if (free_q >= CW'(NUM_TIMERS)) begin
					s_status = ST_FREE;
				end else if (!used_q[tidx]) begin
					s_status = ST_FREE;
				end else if (run_q[tidx]) begin
					s_status = ST_RUNNING;
				end else begin
					do_del = cmd.simple;
				end
			end
			REQ_RELOAD: begin
				if (bad) begin
					s_status = ST_BAD_INDEX;
				end else if (!run_q[tidx]) begin
					s_status = ST_NOT_RUNNING;
				end else if (!used_q[tidx]) begin
					s_status = ST_FREE;
				end else begin
					do_reload = cmd.simple;
				end
			end
			REQ_STOP: begin
				if (bad) begin
					s_status = ST_BAD_INDEX;
				end else if (!run_q[tidx]) begin
					s_status = ST_OK;
				end else if (!used_q[tidx]) begin
					s_status = ST_FREE;
				end else begin
					do_stop = cmd.simple;
				end
			end
			default: begin
				s_status = ST_OK;
			end
		endcase
	end

	assign issue    = cmd.scan && (cnt_q < (IW + 1)'(NUM_TIMERS));
	assign elapsed  = now_q - rd_start_s1;
	assign do_fire  = vld_s1 && (type_q == REQ_TICK) && run_q[idx_s1] &&
	                  (elapsed > rd_tmo_s1) && (fcnt_q < FCW'(MAX_RESULTS));
	assign do_take  = vld_s1 && (type_q == REQ_ADD) && !found_q && !used_q[idx_s1];
	assign do_match = vld_s1 && (type_q == REQ_FIND) && !found_q && used_q[idx_s1] &&
	                  (rd_uid_s1 == uid_q);
	assign fire_per = perf_q[idx_s1];

	assign stat.scan_done = vld_s1 && (idx_s1 == IW'(NUM_TIMERS - 1));

	assign start_we = do_take || (do_fire && fire_per) || do_reload;
	assign start_wa = cmd.simple ? tidx : idx_s1;

	assign found_ext = {4'b0000, found_idx_q};
	assign pend_ext  = {4'b0000, pend_idx_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q <= req_type;
			idx_q  <= slot_index;
			per_q  <= periodic;
			tmo_q  <= timeout_ticks;
			uid_q  <= user_id;
			now_q  <= now_tick;
		end
	end

	always_ff @(posedge clk) begin
		if (start_we) begin
			start_mem[start_wa] <= now_q;
		end
		if (do_take) begin
			tmo_mem[idx_s1] <= tmo_q;
			uid_mem[idx_s1] <= uid_q;
		end
		if (issue) begin
			rd_tmo_s1   <= tmo_mem[cnt_q[IW-1:0]];
			rd_start_s1 <= start_mem[cnt_q[IW-1:0]];
			rd_uid_s1   <= uid_mem[cnt_q[IW-1:0]];
		end
		idx_s1 <= cnt_q[IW-1:0];
		if (do_take || do_match) begin
			found_idx_q <= idx_s1;
		end
		if (do_fire) begin
			pend_idx_q <= idx_s1;
			pend_id_q  <= rd_uid_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			run_q  <= '0;
			perf_q <= '0;
			free_q <= CW'(NUM_TIMERS);
		end else begin
			if (do_del) begin
				used_q[tidx] <= 1'b0;
				free_q       <= free_q + CW'(1);
			end
			if (do_stop) begin
				run_q[tidx] <= 1'b0;
			end
			if (do_take) begin
				used_q[idx_s1] <= 1'b1;
				run_q[idx_s1]  <= 1'b1;
				perf_q[idx_s1] <= per_q;
				free_q         <= free_q - CW'(1);
			end
			if (do_fire && !fire_per) begin
				run_q[idx_s1] <= 1'b0;
				if (used_q[idx_s1]) begin
					used_q[idx_s1] <= 1'b0;
					free_q         <= free_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
			pend_q  <= 1'b0;
			fcnt_q  <= '0;
		end else begin
			vld_s1 <= issue;
			if (cmd.load) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
				pend_q  <= 1'b0;
				fcnt_q  <= '0;
			end else begin
				if (issue) begin
					cnt_q <= cnt_q + (IW + 1)'(1);
				end
				if (do_take || do_match) begin
					found_q <= 1'b1;
				end
				if (do_fire) begin
					pend_q <= 1'b1;
					fcnt_q <= fcnt_q + FCW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.simple || cmd.flush || (do_fire && pend_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.simple) begin
			status_q <= s_status;
			slot_q   <= 4'd0;
			id_q     <= 8'd0;
			fired_q  <= 1'b0;
			last_q   <= 1'b1;
		end else if (do_fire && pend_q) begin
			status_q <= ST_OK;
			slot_q   <= pend_ext[3:0];
			id_q     <= pend_id_q;
			fired_q  <= 1'b1;
			last_q   <= 1'b0;
		end else if (cmd.flush) begin
			last_q <= 1'b1;
			case (type_q)
				REQ_TICK: begin
					status_q <= ST_OK;
					slot_q   <= pend_q ? pend_ext[3:0] : 4'd0;
					id_q     <= pend_q ? pend_id_q : 8'd0;
					fired_q  <= pend_q;
				end
				REQ_ADD: begin
					status_q <= found_q ? ST_OK : ST_FULL;
					slot_q   <= found_q ? found_ext[3:0] : 4'd0;
					id_q     <= 8'd0;
					fired_q  <= 1'b0;
				end
				REQ_FIND: begin
					status_q <= found_q ? ST_OK : ST_NOT_FOUND;
					slot_q   <= found_q ? found_ext[3:0] : 4'd0;
					id_q     <= 8'd0;
					fired_q  <= 1'b0;
				end
				default: begin
					status_q <= ST_OK;
					slot_q   <= 4'd0;
					id_q     <= 8'd0;
					fired_q  <= 1'b0;
				end
			endcase
		end
	end

	assign strobe      = strobe_q;
	assign status      = status_q;
	assign result_slot = slot_q;
	assign fired_id    = id_q;
	assign fired       = fired_q;
	assign last        = last_q;

endmodule

// ===== design/software_timer_pool.sv =====
`timescale 1ns / 1ps
// Delete, reload and stop: busy in the SIMPLE state; the result is registered from it.
// Add, find and tick check: one sweep of the slot memories, one slot per cycle;
// busy through the SCAN and FLUSH states; the last result is registered from FLUSH.
// Fire results stream out during the sweep, one cycle each; results cannot be stalled.
// Reset (arst_n low) frees and stops all slots at once; no clearing pass.

module software_timer_pool #(
	parameter int NUM_TIMERS = swtp_pkg::NUM_TIMERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [7:0]  slot_index,
	input  logic        periodic,
	input  logic [31:0] timeout_ticks,
	input  logic [7:0]  user_id,
	input  logic [31:0] now_tick,
	output logic        strobe,
	output logic [2:0]  status,
	output logic [3:0]  result_slot,
	output logic [7:0]  fired_id,
	output logic        fired,
	output logic        last
);
	import swtp_pkg::*;

	swtp_cmd_t  cmd;
	swtp_stat_t stat;

	swtp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy)
	);

	swtp_datapath #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.req_type      (req_type),
		.slot_index    (slot_index),
		.periodic      (periodic),
		.timeout_ticks (timeout_ticks),
		.user_id       (user_id),
		.now_tick      (now_tick),
		.strobe        (strobe),
		.status        (status),
		.result_slot   (result_slot),
		.fired_id      (fired_id),
		.fired         (fired),
		.last          (last)
	);

endmodule

// ===== design/swtp_checker.sv =====
`timescale 1ns / 1ps
`include "software_timer_pool_assert.svh"

module swtp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [2:0] req_type,
	input logic       strobe,
	input logic [2:0] status,
	input logic       fired,
	input logic       last
);
	import swtp_pkg::*;

	`SWTP_ASSERT_SAME(a_fire_ok, clk, arst_n, strobe && fired, status == ST_OK)
	`SWTP_ASSERT_SAME(a_plain_last, clk, arst_n, strobe && !fired, last)
	`SWTP_ASSERT_SAME(a_idle_last, clk, arst_n, strobe && !busy, last)
	`SWTP_ASSERT_LATER(a_simple_lat, clk, arst_n, 2, start && !busy && (req_type == REQ_DEL || req_type == REQ_RELOAD || req_type == REQ_STOP), strobe && last)
	`SWTP_ASSERT_NEXT(a_scan_busy, clk, arst_n, start && !busy && (req_type == REQ_ADD || req_type == REQ_TICK || req_type == REQ_FIND), busy)

endmodule

bind software_timer_pool swtp_checker u_swtp_checker (.*);

// ===== tb/sv/software_timer_pool_tb.sv =====
`timescale 1ns / 1ps

module software_timer_pool_tb;
	import swtp_pkg::*;

	localparam int NT = NUM_TIMERS_DEF;
	localparam int SETTLE_CYCLES = NT + 8;
	localparam logic [2:0] REQ_RSVD_A = 3'd6;
	localparam logic [2:0] REQ_RSVD_B = 3'd7;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] slot;
		logic [7:0] id;
		logic       fire;
		logic       last;
	} reply_t;

	// timer table mirror: predicts the reply words of each request and checks them
	class timer_table;
		bit        used [NT];
		bit        live [NT];
		bit        reloads [NT];
		bit [31:0] limit [NT];
		bit [31:0] armed_at [NT];
		bit [7:0]  owner [NT];
		int        free_slots;
		reply_t    replies_due [$];
		int        errors;
		int        replies_seen;
		int        expiries;
		int        full_replies;
		int        kind_count [6];

		function new();
			foreach (used[i]) begin
				used[i] = 1'b0;
				live[i] = 1'b0;
				reloads[i] = 1'b0;
				limit[i] = '0;
				armed_at[i] = '0;
				owner[i] = '0;
			end
			foreach (kind_count[k])
				kind_count[k] = 0;
			free_slots = NT;
			errors = 0;
			replies_seen = 0;
			expiries = 0;
			full_replies = 0;
		endfunction

		function void push(logic [2:0] st, int slot, logic [7:0] id, logic fire, logic last);
			reply_t r;
			r.status = st;
			r.slot = 4'(slot);
			r.id = id;
			r.fire = fire;
			r.last = last;
			replies_due.push_back(r);
			if (st == ST_FULL)
				full_replies++;
		endfunction

		function void take_request(logic [2:0] kind, logic [7:0] idx, logic per,
				logic [31:0] tmo, logic [7:0] uid, logic [31:0] now);
			int n;
			int slot;
			bit [31:0] elapsed;
			reply_t r;
			if (kind <= REQ_FIND)
				kind_count[kind]++;
			case (kind)
				REQ_ADD: begin
					slot = -1;
					if (free_slots != 0)
						for (int i = 0; i < NT; i++)
							if (!used[i] && slot < 0)
								slot = i;
					if (slot < 0) begin
						push(ST_FULL, 0, 8'h00, 1'b0, 1'b1);
					end else begin
						used[slot] = 1'b1;
						live[slot] = 1'b1;
						reloads[slot] = per;
						limit[slot] = tmo;
						armed_at[slot] = now;
						owner[slot] = uid;
						free_slots--;
						push(ST_OK, slot, 8'h00, 1'b0, 1'b1);
					end
				end
				REQ_DEL: begin
					if (idx >= NT)
						push(ST_BAD_INDEX, 0, 8'h00, 1'b0, 1'b1);
					else if (free_slots >= NT || !used[idx])
						push(ST_FREE, 0, 8'h00, 1'b0, 1'b1);
					else if (live[idx])
						push(ST_RUNNING, 0, 8'h00, 1'b0, 1'b1);
					else begin
						used[idx] = 1'b0;
						free_slots++;
						push(ST_OK, 0, 8'h00, 1'b0, 1'b1);
					end
				end
				REQ_RELOAD: begin
					if (idx >= NT)
						push(ST_BAD_INDEX, 0, 8'h00, 1'b0, 1'b1);
					else if (!live[idx])
						push(ST_NOT_RUNNING, 0, 8'h00, 1'b0, 1'b1);
					else if (!used[idx])
						push(ST_FREE, 0, 8'h00, 1'b0, 1'b1);
					else begin
						armed_at[idx] = now;
						push(ST_OK, 0, 8'h00, 1'b0, 1'b1);
					end
				end
				REQ_STOP: begin
					if (idx >= NT)
						push(ST_BAD_INDEX, 0, 8'h00, 1'b0, 1'b1);
					else if (!live[idx])
						push(ST_OK, 0, 8'h00, 1'b0, 1'b1);
					else if (!used[idx])
						push(ST_FREE, 0, 8'h00, 1'b0, 1'b1);
					else begin
						live[idx] = 1'b0;
						push(ST_OK, 0, 8'h00, 1'b0, 1'b1);
					end
				end
				REQ_TICK: begin
					n = 0;
					for (int i = 0; i < NT; i++) begin
						elapsed = now - armed_at[i];
						if (n < MAX_RESULTS && live[i] && elapsed > limit[i]) begin
							push(ST_OK, i, owner[i], 1'b1, 1'b0);
							n++;
							if (reloads[i])
								armed_at[i] = now;
							else begin
								live[i] = 1'b0;
								if (used[i]) begin
									used[i] = 1'b0;
									free_slots++;
								end
							end
						end
					end
					expiries += n;
					if (n == 0)
						push(ST_OK, 0, 8'h00, 1'b0, 1'b1);
					else begin
						r = replies_due.pop_back();
						r.last = 1'b1;
						replies_due.push_back(r);
					end
				end
				REQ_FIND: begin
					slot = -1;
					for (int i = 0; i < NT; i++)
						if (used[i] && owner[i] == uid && slot < 0)
							slot = i;
					if (slot < 0)
						push(ST_NOT_FOUND, 0, 8'h00, 1'b0, 1'b1);
					else
						push(ST_OK, slot, 8'h00, 1'b0, 1'b1);
				end
				default: ;
			endcase
		endfunction

		task report(string what);
			if (errors < 30)
				$display("[%0t] mismatch: %s", $realtime, what);
			errors++;
		endtask

		task check_reply(reply_t got);
			reply_t want;
			replies_seen++;
			if (replies_due.size() == 0) begin
				report($sformatf("unexpected word st=%0d slot=%0d id=%02h fired=%b last=%b",
					got.status, got.slot, got.id, got.fire, got.last));
				return;
			end
			want = replies_due.pop_front();
			if (got.status !== want.status)
				report($sformatf("word %0d status %0d, want %0d", replies_seen, got.status,
					want.status));
			if (got.slot !== want.slot)
				report($sformatf("word %0d result_slot %0d, want %0d", replies_seen, got.slot,
					want.slot));
			if (got.id !== want.id)
				report($sformatf("word %0d fired_id %02h, want %02h", replies_seen, got.id,
					want.id));
			if (got.fire !== want.fire)
				report($sformatf("word %0d fired %b, want %b", replies_seen, got.fire,
					want.fire));
			if (got.last !== want.last)
				report($sformatf("word %0d last %b, want %b", replies_seen, got.last,
					want.last));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  req_type;
	logic [7:0]  slot_index;
	logic        periodic;
	logic [31:0] timeout_ticks;
	logic [7:0]  user_id;
	logic [31:0] now_tick;
	logic        strobe;
	logic [2:0]  status;
	logic [3:0]  result_slot;
	logic [7:0]  fired_id;
	logic        fired;
	logic        last;

	timer_table  pool;
	int          idle_pct;
	logic [31:0] clock_now;
	int          pace [4] = '{0, 62, 0, 13};

	software_timer_pool uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.slot_index(slot_index),
		.periodic(periodic),
		.timeout_ticks(timeout_ticks),
		.user_id(user_id),
		.now_tick(now_tick),
		.strobe(strobe),
		.status(status),
		.result_slot(result_slot),
		.fired_id(fired_id),
		.fired(fired),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && strobe)
			pool.check_reply(reply_t'{status, result_slot, fired_id, fired, last});
	end

	task automatic issue(logic [2:0] kind, logic [7:0] idx, logic per, logic [31:0] tmo,
			logic [7:0] uid, logic [31:0] now);
		int gap;
		gap = ($urandom_range(0, 99) < idle_pct) ? int'($urandom_range(1, 24)) : 0;
		@(negedge clk);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type = kind;
		slot_index = idx;
		periodic = per;
		timeout_ticks = tmo;
		user_id = uid;
		now_tick = now;
		start = 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pool.take_request(kind, idx, per, tmo, uid, now);
	endtask

	// hold off until every expected word is back
	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (pool.replies_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic random_request();
		int          sel;
		logic [2:0]  kind;
		logic [7:0]  idx;
		logic [7:0]  uid;
		logic        per;
		logic [31:0] tmo;
		logic [31:0] now;
		sel = $urandom_range(0, 99);
		per = 1'($urandom_range(0, 1));
		tmo = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 40));
		uid = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) :
			8'($urandom_range(0, 7));
		idx = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) :
			8'($urandom_range(0, NT - 1));
		if (sel < 30) begin
			kind = REQ_ADD;
			clock_now += 32'($urandom_range(0, 3));
		end else if (sel < 55) begin
			kind = REQ_TICK;
			clock_now += 32'($urandom_range(0, 25));
		end else if (sel < 65) begin
			kind = REQ_DEL;
			if ($urandom_range(0, 1) == 1)
				for (int i = 0; i < NT; i++)
					if (pool.used[i] && !pool.live[i])
						idx = 8'(i);
		end else if (sel < 75) begin
			kind = REQ_RELOAD;
			clock_now += 32'($urandom_range(0, 5));
		end else if (sel < 85) begin
			kind = REQ_STOP;
		end else if (sel < 95) begin
			kind = REQ_FIND;
		end else begin
			kind = 3'($urandom_range(0, 7));
		end
		now = clock_now;
		if (sel >= 95) begin
			now = $urandom;
			tmo = $urandom;
			uid = 8'($urandom_range(0, 255));
			idx = 8'($urandom_range(0, 255));
		end
		issue(kind, idx, per, tmo, uid, now);
	endtask

	// empty the pool, fill it past full with zero timeouts, then expire every slot at once
	task automatic flush_pool();
		for (int i = 0; i < NT; i++) begin
			if (pool.used[i]) begin
				if (pool.live[i])
					issue(REQ_STOP, 8'(i), 1'b0, 32'h0, 8'h00, clock_now);
				issue(REQ_DEL, 8'(i), 1'b0, 32'h0, 8'h00, clock_now);
			end
		end
		repeat (NT + 1)
			issue(REQ_ADD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 32'h0,
				8'($urandom_range(0, 255)), clock_now);
		clock_now += 32'd1;
		issue(REQ_TICK, 8'($urandom_range(0, 255)), 1'b0, 32'h0, 8'h00, clock_now);
	endtask

	initial begin
		pool = new();
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_ADD;
		slot_index = '0;
		periodic = 1'b0;
		timeout_ticks = '0;
		user_id = '0;
		now_tick = '0;
		idle_pct = 0;
		clock_now = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		issue(REQ_TICK, 8'h00, 1'b0, 32'h0, 8'h00, 32'h0);
		issue(REQ_FIND, 8'h00, 1'b0, 32'h0, 8'h00, 32'h0);
		issue(REQ_DEL, 8'h00, 1'b0, 32'h0, 8'h00, 32'h0);
		issue(REQ_RELOAD, 8'h00, 1'b0, 32'h0, 8'h00, 32'h0);
		issue(REQ_STOP, 8'h00, 1'b0, 32'h0, 8'h00, 32'h0);
		issue(REQ_DEL, 8'd16, 1'b0, 32'h0, 8'h00, 32'h0);
		issue(REQ_RELOAD, 8'hFF, 1'b0, 32'h0, 8'h00, 32'h0);
		issue(REQ_STOP, 8'd200, 1'b0, 32'h0, 8'h00, 32'h0);
		issue(REQ_ADD, 8'hFF, 1'b1, 32'h0, 8'hFF, 32'hFFFF_FFFF);
		issue(REQ_ADD, 8'h00, 1'b0, 32'hFFFF_FFFF, 8'h00, 32'h0);
		issue(REQ_ADD, 8'h00, 1'b0, 32'd5, 8'h5A, 32'hFFFF_FFFE);
		// wrap: nothing has exceeded its timeout yet
		issue(REQ_TICK, 8'h00, 1'b0, 32'h0, 8'h00, 32'hFFFF_FFFF);
		issue(REQ_TICK, 8'h00, 1'b0, 32'h0, 8'h00, 32'd4);
		issue(REQ_FIND, 8'h00, 1'b0, 32'h0, 8'h5A, 32'd4);
		issue(REQ_FIND, 8'h00, 1'b0, 32'h0, 8'h00, 32'd4);
		issue(REQ_DEL, 8'd1, 1'b0, 32'h0, 8'h00, 32'd5);
		issue(REQ_STOP, 8'd1, 1'b0, 32'h0, 8'h00, 32'd5);
		issue(REQ_STOP, 8'd1, 1'b0, 32'h0, 8'h00, 32'd5);
		issue(REQ_RELOAD, 8'd1, 1'b0, 32'h0, 8'h00, 32'd6);
		issue(REQ_DEL, 8'd1, 1'b0, 32'h0, 8'h00, 32'd6);
		issue(REQ_DEL, 8'd1, 1'b0, 32'h0, 8'h00, 32'd6);
		issue(REQ_RELOAD, 8'd0, 1'b0, 32'h0, 8'h00, 32'd10);
		issue(REQ_RSVD_A, 8'd0, 1'b1, 32'hFFFF_FFFF, 8'hFF, 32'd10);
		issue(REQ_RSVD_B, 8'hFF, 1'b1, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
		issue(REQ_FIND, 8'h00, 1'b0, 32'h0, 8'hFF, 32'd11);
		settle();

		for (int p = 0; p < 4; p++) begin
			idle_pct = pace[p];
			case (p)
				0: clock_now = 32'd100;
				1: clock_now = 32'hFFFF_FF80;
				default: clock_now = $urandom;
			endcase
			repeat (15) random_request();
			flush_pool();
			repeat (15) random_request();
			settle();
		end

		$display("coverage: %0d add, %0d delete, %0d reload, %0d stop, %0d tick, %0d find requests",
			pool.kind_count[REQ_ADD], pool.kind_count[REQ_DEL], pool.kind_count[REQ_RELOAD],
			pool.kind_count[REQ_STOP], pool.kind_count[REQ_TICK], pool.kind_count[REQ_FIND]);
		$display("%0d words checked, %0d expiries, %0d pool-full replies, %0d mismatches",
			pool.replies_seen, pool.expiries, pool.full_replies, pool.errors);
		if (pool.errors == 0 && pool.replies_due.size() == 0)
			$display("software_timer_pool_tb OK");
		else
			$display("software_timer_pool_tb NOT OK");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("timeout: %0d words still expected", pool.replies_due.size());
		$display("software_timer_pool_tb NOT OK");
		$finish;
	end

endmodule
